// ----- src/rv_subset_single_cycle_core_assert.svh -----
// Assertion macros used by the core's top-level RTL file.
`ifndef RV_SUBSET_SINGLE_CYCLE_CORE_ASSERT_SVH
`define RV_SUBSET_SINGLE_CYCLE_CORE_ASSERT_SVH

// Implication or plain property checked on every clock edge outside reset.
`define RVSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true on a clock edge outside reset.
`define RVSC_NEVER(lbl, cond, msg) \
  `RVSC_ASSERT(lbl, !(cond), msg)

`endif

// ----- src/rvsc_pkg.sv -----
// Shared constants, types and opcodes of the RV64I subset core.
package rvsc_pkg;

  localparam int XLEN          = 64;
  localparam int ILEN          = 32;
  localparam int RF_DEPTH      = 32;
  localparam int RF_AW         = 5;
  localparam int DATA_WORDS_DEF = 1024;

  // Remainder unit: bits of the address consumed per cycle.
  localparam int WRAP_STEPS  = 8;
  localparam int WRAP_CYC    = XLEN / WRAP_STEPS;
  localparam int WRAP_CNT_W  = $clog2(WRAP_CYC);

  localparam logic [6:0] OPC_R     = 7'b0110011;
  localparam logic [6:0] OPC_IARI  = 7'b0010011;
  localparam logic [6:0] OPC_JALR  = 7'b1100111;
  localparam logic [6:0] OPC_LOAD  = 7'b0000011;
  localparam logic [6:0] OPC_STORE = 7'b0100011;
  localparam logic [6:0] OPC_JAL   = 7'b1101111;

  localparam logic [2:0] F3_ADD = 3'b000;
  localparam logic [2:0] F3_XOR = 3'b100;
  localparam logic [2:0] F3_OR  = 3'b110;
  localparam logic [2:0] F3_AND = 3'b111;

  // Configuration register indexes (bit 3 of the byte address).
  localparam logic CFG_HALT_REG = 1'b0;
  localparam logic CFG_HALT_VAL = 1'b1;

  localparam logic [RF_AW-1:0] HALT_REG_RST = 5'd9;
  localparam logic [XLEN-1:0]  HALT_VAL_RST = 64'd10;

  typedef struct packed {
    logic             en;
    logic [RF_AW-1:0] addr;
    logic [XLEN-1:0]  data;
  } rf_wr_t;

  typedef enum logic [1:0] {
    WRAP_IDLE,
    WRAP_RUN,
    WRAP_DONE
  } wrap_st_t;

endpackage

// ----- src/rvsc_regfile.sv -----
// Register file: 32 x 64-bit synchronous memory, two read ports, one write port.
module rvsc_regfile (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [rvsc_pkg::RF_AW-1:0]  rd_addr_a,
  input  logic [rvsc_pkg::RF_AW-1:0]  rd_addr_b,
  input  rvsc_pkg::rf_wr_t            wr,
  output logic [rvsc_pkg::XLEN-1:0]   q_a,
  output logic [rvsc_pkg::XLEN-1:0]   q_b
);
  import rvsc_pkg::*;

  logic [XLEN-1:0]     mem [RF_DEPTH];
  logic [RF_DEPTH-1:0] vld_r;
  logic [XLEN-1:0]     dat_a_r;
  logic [XLEN-1:0]     dat_b_r;
  logic [XLEN-1:0]     fwd_val_r;
  logic                vld_a_r;
  logic                vld_b_r;
  logic                hit_a_r;
  logic                hit_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      dat_a_r   <= mem[rd_addr_a];
      dat_b_r   <= mem[rd_addr_b];
      fwd_val_r <= wr.data;
    end
  end

  // Entries never written read as zero; a write landing on the read edge is bypassed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      hit_a_r <= 1'b0;
      hit_b_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_a_r <= vld_r[rd_addr_a];
        vld_b_r <= vld_r[rd_addr_b];
        hit_a_r <= wr.en && (wr.addr == rd_addr_a);
        hit_b_r <= wr.en && (wr.addr == rd_addr_b);
      end
    end
  end

  assign q_a = hit_a_r ? fwd_val_r : (vld_a_r ? dat_a_r : '0);
  assign q_b = hit_b_r ? fwd_val_r : (vld_b_r ? dat_b_r : '0);

endmodule

// ----- src/rvsc_dmem.sv -----
// Data store: synchronous memory with one read port and one write port, and a clearing sweep after reset.
module rvsc_dmem #(
  parameter int DATA_WORDS = rvsc_pkg::DATA_WORDS_DEF,
  parameter int IW         = $clog2(DATA_WORDS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [IW-1:0]             rd_idx,
  input  logic                      wr_en,
  input  logic [IW-1:0]             wr_idx,
  input  logic [rvsc_pkg::XLEN-1:0] wr_data,
  output logic [rvsc_pkg::XLEN-1:0] q,
  output logic                      busy
);
  import rvsc_pkg::*;

  logic [XLEN-1:0] mem [DATA_WORDS];
  logic [XLEN-1:0] q_r;
  logic [IW-1:0]   clr_idx_r;
  logic            busy_r;

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else if (busy_r) begin
      if (clr_idx_r == IW'(DATA_WORDS - 1)) begin
        busy_r <= 1'b0;
      end else begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  assign q    = q_r;
  assign busy = busy_r;

endmodule

// ----- src/rvsc_wrap.sv -----
// Reduces a 64-bit effective address to a data store index modulo the depth.
module rvsc_wrap #(
  parameter int DATA_WORDS = rvsc_pkg::DATA_WORDS_DEF,
  parameter int IW         = $clog2(DATA_WORDS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      clr,
  input  logic [rvsc_pkg::XLEN-1:0] addr,
  output logic                      done,
  output logic [IW-1:0]             idx
);
  import rvsc_pkg::*;

  localparam bit POW2 = (DATA_WORDS & (DATA_WORDS - 1)) == 0;

  generate
    if (POW2) begin : g_mask
      // Power-of-two depth: the remainder is the low address bits.
      assign done = 1'b1;
      assign idx  = addr[IW-1:0];
    end else begin : g_iter
      localparam logic [IW:0] NW = (IW + 1)'(DATA_WORDS);
      localparam logic [WRAP_CNT_W-1:0] CNT_LAST = WRAP_CNT_W'(WRAP_CYC - 1);

      wrap_st_t              st_r;
      wrap_st_t              st_nxt;
      logic [IW-1:0]         rem_r;
      logic [IW-1:0]         rem_nxt;
      logic [XLEN-1:0]       sh_r;
      logic [XLEN-1:0]       sh_nxt;
      logic [WRAP_CNT_W-1:0] cnt_r;
      logic [IW:0]           t_v;

      // Restoring remainder, several address bits per cycle, most significant first.
      always_comb begin
        rem_nxt = rem_r;
        sh_nxt  = sh_r;
        t_v     = '0;
        for (int k = 0; k < WRAP_STEPS; k++) begin
          t_v    = {rem_nxt, sh_nxt[XLEN-1]};
          sh_nxt = {sh_nxt[XLEN-2:0], 1'b0};
          if (t_v >= NW) begin
            t_v = t_v - NW;
          end
          rem_nxt = t_v[IW-1:0];
        end
      end

      always_comb begin
        st_nxt = st_r;
        unique case (st_r)
          WRAP_IDLE: if (start) st_nxt = WRAP_RUN;
          WRAP_RUN:  if (cnt_r == CNT_LAST) st_nxt = WRAP_DONE;
          WRAP_DONE: if (clr) st_nxt = WRAP_IDLE;
          default:   st_nxt = WRAP_IDLE;
        endcase
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          st_r <= WRAP_IDLE;
        end else begin
          st_r <= st_nxt;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cnt_r <= '0;
        end else if (st_r == WRAP_IDLE) begin
          cnt_r <= '0;
        end else if (st_r == WRAP_RUN) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (st_r == WRAP_IDLE && start) begin
          rem_r <= '0;
          sh_r  <= addr;
        end else if (st_r == WRAP_RUN) begin
          rem_r <= rem_nxt;
          sh_r  <= sh_nxt;
        end
      end

      assign done = (st_r == WRAP_DONE);
      assign idx  = rem_r;
    end
  endgenerate

endmodule

// ----- src/rv_subset_single_cycle_core.sv -----
// Top level of the RV64I subset core: decode, execute, writeback and control.
//
//  channel  direction  handshake                      payload
//  in_      slave      in_tvalid / in_tready          in_tdata: 32-bit instruction word
//  out_     master     out_tvalid / out_tready        out_tdata: one result per instruction
//  cfg_     apb slave  psel, penable, pwrite, pready  halt_register @0x0, halt_value @0x8
//
// An ALU, jump, branch or store instruction completes in execute; a new transfer is
// accepted every cycle unless a held result, a configuration write or the sweep stalls
// it. A load moves on to writeback for the data store's registered read. For a data store
// depth that is not a power of two, loads and stores wait for the address remainder unit.
// After reset the data store is swept to zero, one word per cycle; in_tready stays low
// until the sweep ends. A result that is not taken holds in the output register; execute
// stalls behind it while one more instruction may still wait in execute.
`include "rv_subset_single_cycle_core_assert.svh"

module rv_subset_single_cycle_core #(
  parameter int DATA_WORDS = rvsc_pkg::DATA_WORDS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,     // [31:0] instr_word
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,    // [31:0] next_pc, [32] reg_write, [37:33] dest_reg,
                                     // [101:38] write_value, [102] mem_write, [103] halted
  // Configuration port.
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  import rvsc_pkg::*;

  localparam int IW = $clog2(DATA_WORDS);

  // Configuration.
  logic             cfg_wr;
  logic             cfg_wr_hr;
  logic [RF_AW-1:0] halt_reg_r;
  logic [XLEN-1:0]  halt_val_r;
  logic             refresh_r;
  logic [XLEN-1:0]  watched_r;
  logic [XLEN-1:0]  watch_nxt;
  logic             halt_hit;

  // Pipeline control.
  logic             in_accept;
  logic             out_free;
  logic             ex_valid_r;
  logic [ILEN-1:0]  ex_instr_r;
  logic             wb_valid_r;
  logic [RF_AW-1:0] wb_rd_r;
  logic [31:0]      wb_npc_r;
  logic [31:0]      pc_r;
  logic             ex_done;
  logic             ex_to_wb;
  logic             wb_done;

  // Decode and execute.
  logic [6:0]       opc;
  logic [RF_AW-1:0] rd_f;
  logic [2:0]       f3;
  logic             is_r, is_i, is_jalr, is_load, is_store, is_jal, is_mem;
  logic [XLEN-1:0]  rs1_val, rs2_val;
  logic [XLEN-1:0]  imm_i, imm_s, imm_b, imm_j;
  logic [XLEN-1:0]  op2;
  logic [XLEN-1:0]  sum;
  logic [XLEN-1:0]  alu;
  logic [XLEN-1:0]  agu;
  logic [31:0]      link;
  logic [31:0]      br_tgt;
  logic [31:0]      npc;
  logic             ex_wr;
  logic [XLEN-1:0]  ex_val;
  logic             ex_wr_eff;

  // Memories.
  rf_wr_t           rf_wr;
  logic [RF_AW-1:0] rf_addr_a;
  logic             rf_rd_en;
  logic [XLEN-1:0]  dm_q;
  logic             dm_busy;
  logic             idx_ok;
  logic [IW-1:0]    dm_idx;

  // Output register.
  logic             out_valid_r;
  logic [31:0]      out_npc_r;
  logic             out_wr_r;
  logic [RF_AW-1:0] out_rd_r;
  logic [XLEN-1:0]  out_val_r;
  logic             out_mw_r;
  logic             out_halt_r;

  // ---------------------------------------------------------------------------
  // Configuration port. The register index is address bit 3; lower bits alias.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_wr_hr  = cfg_wr & (cfg_paddr[3] == CFG_HALT_REG);
  assign cfg_prdata = (cfg_paddr[3] == CFG_HALT_VAL) ? halt_val_r
                                                     : {{(64 - RF_AW){1'b0}}, halt_reg_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halt_reg_r <= HALT_REG_RST;
      halt_val_r <= HALT_VAL_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[3] == CFG_HALT_REG) begin
        halt_reg_r <= cfg_pwdata[RF_AW-1:0];
      end else begin
        halt_val_r <= cfg_pwdata;
      end
    end
  end

  // The watched register's value is kept in a shadow register. A new halt index
  // reads the register file on port A at the configuration transfer; the value is
  // taken over from the registered read port while refresh_r is set.
  always_comb begin
    watch_nxt = watched_r;
    if (rf_wr.en && (rf_wr.addr == halt_reg_r)) begin
      watch_nxt = rf_wr.data;
    end
  end

  assign halt_hit = (watch_nxt == halt_val_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_r <= 1'b0;
      watched_r <= '0;
    end else begin
      refresh_r <= cfg_wr_hr;
      watched_r <= refresh_r ? rs1_val : watch_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. Execute holds one instruction; writeback holds only a load, and
  // while it does execute stays empty, so there is at most one register write per cycle.
  // ---------------------------------------------------------------------------
  assign out_free  = ~out_valid_r | out_tready;
  assign in_tready = ~dm_busy & ~cfg_wr & (~ex_valid_r | ex_done) & (~wb_valid_r | wb_done);
  assign in_accept = in_tvalid & in_tready;

  assign ex_done  = ex_valid_r & ~is_load & out_free & (~is_store | idx_ok);
  assign ex_to_wb = ex_valid_r & is_load & idx_ok;
  assign wb_done  = wb_valid_r & out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r <= 1'b0;
      wb_valid_r <= 1'b0;
      pc_r       <= '0;
    end else begin
      if (in_accept) begin
        ex_valid_r <= 1'b1;
      end else if (ex_done || ex_to_wb) begin
        ex_valid_r <= 1'b0;
      end
      if (ex_to_wb) begin
        wb_valid_r <= 1'b1;
      end else if (wb_done) begin
        wb_valid_r <= 1'b0;
      end
      if (ex_done || ex_to_wb) begin
        pc_r <= npc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ex_instr_r <= in_tdata;
    end
    if (ex_to_wb) begin
      wb_rd_r  <= rd_f;
      wb_npc_r <= npc;
    end
  end

  // ---------------------------------------------------------------------------
  // Register file: operands are read at the input transfer and used in execute.
  // ---------------------------------------------------------------------------
  assign rf_rd_en  = in_accept | cfg_wr_hr;
  assign rf_addr_a = cfg_wr_hr ? cfg_pwdata[RF_AW-1:0] : in_tdata[19:15];

  rvsc_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (rf_rd_en),
    .rd_addr_a (rf_addr_a),
    .rd_addr_b (in_tdata[24:20]),
    .wr        (rf_wr),
    .q_a       (rs1_val),
    .q_b       (rs2_val)
  );

  // Loads write back from the data store output; everything else from execute.
  // Writes to x0 are dropped here, which keeps x0 at zero.
  always_comb begin
    rf_wr.en   = 1'b0;
    rf_wr.addr = rd_f;
    rf_wr.data = ex_val;
    if (wb_done) begin
      rf_wr.en   = (wb_rd_r != '0);
      rf_wr.addr = wb_rd_r;
      rf_wr.data = dm_q;
    end else if (ex_done) begin
      rf_wr.en   = ex_wr_eff;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode and execute.
  // ---------------------------------------------------------------------------
  assign opc  = ex_instr_r[6:0];
  assign rd_f = ex_instr_r[11:7];
  assign f3   = ex_instr_r[14:12];

  assign is_r     = (opc == OPC_R);
  assign is_i     = (opc == OPC_IARI);
  assign is_jalr  = (opc == OPC_JALR);
  assign is_load  = (opc == OPC_LOAD);
  assign is_store = (opc == OPC_STORE);
  assign is_jal   = (opc == OPC_JAL);
  assign is_mem   = is_load | is_store;

  assign imm_i = {{52{ex_instr_r[31]}}, ex_instr_r[31:20]};
  assign imm_s = {{52{ex_instr_r[31]}}, ex_instr_r[31:25], ex_instr_r[11:7]};
  assign imm_b = {{51{ex_instr_r[31]}}, ex_instr_r[31], ex_instr_r[7],
                  ex_instr_r[30:25], ex_instr_r[11:8], 1'b0};
  assign imm_j = {{43{ex_instr_r[31]}}, ex_instr_r[31], ex_instr_r[19:12],
                  ex_instr_r[20], ex_instr_r[30:21], 1'b0};

  // R-type and I-type arithmetic share one ALU; unsupported func3 codes add.
  always_comb begin
    op2 = is_r ? rs2_val : imm_i;
    sum = (is_r && (f3 == F3_ADD) && ex_instr_r[30]) ? (rs1_val - op2) : (rs1_val + op2);
    case (f3)
      F3_XOR:  alu = rs1_val ^ op2;
      F3_OR:   alu = rs1_val | op2;
      F3_AND:  alu = rs1_val & op2;
      default: alu = sum;
    endcase
  end

  // Address adder serves loads, stores and the jalr target.
  assign agu    = rs1_val + (is_store ? imm_s : imm_i);
  assign link   = pc_r + 32'd4;
  assign br_tgt = pc_r + (is_jal ? imm_j[31:0] : imm_b[31:0]);

  // Any opcode that is not recognized behaves as beq.
  always_comb begin
    npc = link;
    if (is_jalr) begin
      npc = {agu[31:1], 1'b0};
    end else if (is_jal) begin
      npc = br_tgt;
    end else if (!(is_r || is_i || is_mem)) begin
      if (rs1_val == rs2_val) begin
        npc = br_tgt;
      end
    end
  end

  assign ex_wr     = is_r | is_i | is_jalr | is_jal;
  assign ex_val    = (is_jalr || is_jal) ? {32'd0, link} : alu;
  assign ex_wr_eff = ex_wr & (rd_f != '0);

  // ---------------------------------------------------------------------------
  // Data store and its index.
  // ---------------------------------------------------------------------------
  rvsc_wrap #(
    .DATA_WORDS (DATA_WORDS),
    .IW         (IW)
  ) u_wrap (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ex_valid_r & is_mem),
    .clr   (ex_done | ex_to_wb),
    .addr  (agu),
    .done  (idx_ok),
    .idx   (dm_idx)
  );

  rvsc_dmem #(
    .DATA_WORDS (DATA_WORDS),
    .IW         (IW)
  ) u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (ex_to_wb),
    .rd_idx  (dm_idx),
    .wr_en   (ex_done & is_store),
    .wr_idx  (dm_idx),
    .wr_data (rs2_val),
    .q       (dm_q),
    .busy    (dm_busy)
  );

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ex_done || wb_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_done) begin
      out_npc_r  <= wb_npc_r;
      out_wr_r   <= rf_wr.en;
      out_rd_r   <= rf_wr.en ? wb_rd_r : '0;
      out_val_r  <= rf_wr.en ? dm_q : '0;
      out_mw_r   <= 1'b0;
      out_halt_r <= halt_hit;
    end else if (ex_done) begin
      out_npc_r  <= npc;
      out_wr_r   <= ex_wr_eff;
      out_rd_r   <= ex_wr_eff ? rd_f : '0;
      out_val_r  <= ex_wr_eff ? ex_val : '0;
      out_mw_r   <= is_store;
      out_halt_r <= halt_hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_halt_r, out_mw_r, out_val_r, out_rd_r, out_wr_r, out_npc_r};

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `RVSC_ASSERT(a_wb_excl, wb_valid_r |-> !ex_valid_r, "load in writeback while execute busy")
  `RVSC_NEVER(a_one_wr, ex_done && wb_done, "execute and writeback complete together")
  `RVSC_ASSERT(a_x0, rf_wr.en |-> (rf_wr.addr != '0), "write to x0 reached register file")
  `RVSC_ASSERT(a_sweep, dm_busy |-> !in_tready, "transfer accepted during memory sweep")

endmodule
